/* hw/rtl/bu2x_pkg.sv */
// ----------------------------------------------------------------------------
// bu2x_pkg
// Shared types, constants and helpers for the 2x bilinear upscaler.
// ----------------------------------------------------------------------------
package bu2x_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int COLS_W     = 12;
    localparam int ROWS_W     = 13;
    localparam int OROW_W     = 13;
    localparam int OCOL_W     = 12;
    localparam int PX_W       = 24;

    // Low bits of the input position that reach the masked output coordinates
    localparam int RTAG_W = OROW_W - 1;
    localparam int CTAG_W = OCOL_W - 1;

    localparam logic [CFG_IDX_W-1:0] REG_IN_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_ROWS = 1'b1;

    localparam logic [COLS_W-1:0] IN_COLS_RST = 12'd2048;
    localparam logic [ROWS_W-1:0] IN_ROWS_RST = 13'd4096;

    // Output row phase relative to 2r, and column phase relative to 2c
    localparam logic [1:0] PH_ABOVE = 2'd0;
    localparam logic [1:0] PH_SAME  = 2'd1;
    localparam logic [1:0] PH_BELOW = 2'd2;
    localparam logic [1:0] K_LEFT   = 2'd0;
    localparam logic [1:0] K_MID    = 2'd1;
    localparam logic [1:0] K_RIGHT  = 2'd2;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef logic [PX_W-1:0] px_t;   // blue [7:0], green [15:8], red [23:16]

    typedef struct packed {
        px_t               cur0;     // mean of left and current pixel
        px_t               cur;      // current pixel
        px_t               upv0;     // mean of upper-left and upper pixel
        px_t               upv;      // pixel above
        logic [RTAG_W-1:0] row;
        logic [CTAG_W-1:0] col;
        logic              has_above;
        logic              has_left;
        logic              last_col;
        logic              last_row;
    } q_entry_t;

    function automatic px_t px_mean(input px_t a, input px_t b);
        logic [8:0] s0;
        logic [8:0] s1;
        logic [8:0] s2;
        s0 = {1'b0, a[7:0]}   + {1'b0, b[7:0]};
        s1 = {1'b0, a[15:8]}  + {1'b0, b[15:8]};
        s2 = {1'b0, a[23:16]} + {1'b0, b[23:16]};
        return {s2[8:1], s1[8:1], s0[8:1]};
    endfunction

endpackage

/* hw/rtl/bu2x_if.sv */
// ----------------------------------------------------------------------------
// bu2x interfaces
// Valid/ready channels for input pixels, result pixels and register writes.
// ----------------------------------------------------------------------------
interface bu2x_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;

    modport source (output valid, output in_blue, output in_green, output in_red,
                    input ready);
    modport sink   (input valid, input in_blue, input in_green, input in_red,
                    output ready);
endinterface

interface bu2x_res_if;
    logic                        valid;
    logic                        ready;
    logic [bu2x_pkg::OROW_W-1:0] out_row;
    logic [bu2x_pkg::OCOL_W-1:0] out_col;
    logic [7:0]                  out_blue;
    logic [7:0]                  out_green;
    logic [7:0]                  out_red;
    logic                        last_of_run;

    modport source (output valid, output out_row, output out_col, output out_blue,
                    output out_green, output out_red, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_row, input out_col, input out_blue,
                    input out_green, input out_red, input last_of_run,
                    output ready);
endinterface

interface bu2x_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bu2x_pkg::CFG_IDX_W-1:0]  index;
    logic [bu2x_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/bu2x_front.sv */
// ----------------------------------------------------------------------------
// bu2x_front
// Accepts pixels and register writes, tracks position, reads/writes the line
// store and builds one queue word per pixel.
// ----------------------------------------------------------------------------
module bu2x_front #(
    parameter int MAX_COLS = 2048,
    parameter int MAX_ROWS = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    bu2x_pix_if.sink            pixel,
    bu2x_cfg_if.sink            cfg,
    output logic                push,
    output bu2x_pkg::q_entry_t  push_word,
    input  logic                q_full
);

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [13:0] MAX_C = 14'(MAX_COLS);
    localparam logic [14:0] MAX_R = 15'(MAX_ROWS);

    logic [bu2x_pkg::COLS_W-1:0] in_cols_reg;
    logic [bu2x_pkg::ROWS_W-1:0] in_rows_reg;
    logic [CW-1:0]               col_reg;
    logic [RW-1:0]               row_reg;
    bu2x_pkg::px_t               left_cur_reg;
    bu2x_pkg::px_t               left_prev_reg;
    bu2x_pkg::px_t               store [MAX_COLS];

    logic                                s1_vld_reg;
    bu2x_pkg::px_t                       s1_px_reg;
    bu2x_pkg::px_t                       s1_left_reg;
    bu2x_pkg::px_t                       s1_up_reg;
    logic [bu2x_pkg::RTAG_W-1:0]         s1_row_reg;
    logic [bu2x_pkg::CTAG_W-1:0]         s1_col_reg;
    logic                                s1_above_reg;
    logic                                s1_left_ok_reg;
    logic                                s1_last_col_reg;
    logic                                s1_last_row_reg;

    logic          acc;
    logic          cfg_wr;
    logic [13:0]   cols_eff;
    logic [14:0]   rows_eff;
    logic          last_col;
    logic          last_row;
    bu2x_pkg::px_t pix;

    assign pix      = {pixel.in_red, pixel.in_green, pixel.in_blue};
    assign push     = s1_vld_reg && !q_full;
    assign pixel.ready = !s1_vld_reg || !q_full;
    assign acc      = pixel.valid && pixel.ready;
    assign cfg.ready = 1'b1;
    assign cfg_wr   = cfg.valid;

    assign cols_eff = (in_cols_reg == '0) ? 14'd1
                    : ((14'(in_cols_reg) > MAX_C) ? MAX_C : 14'(in_cols_reg));
    assign rows_eff = (in_rows_reg == '0) ? 15'd1
                    : ((15'(in_rows_reg) > MAX_R) ? MAX_R : 15'(in_rows_reg));
    assign last_col = (15'(col_reg) + 15'd1) >= 15'(cols_eff);
    assign last_row = (16'(row_reg) + 16'd1) >= 16'(rows_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cols_reg   <= bu2x_pkg::IN_COLS_RST;
            in_rows_reg   <= bu2x_pkg::IN_ROWS_RST;
            col_reg       <= '0;
            row_reg       <= '0;
            left_cur_reg  <= '0;
            left_prev_reg <= '0;
            s1_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (cfg.index == bu2x_pkg::REG_IN_COLS)
                begin
                    in_cols_reg <= cfg.data[bu2x_pkg::COLS_W-1:0];
                end
                else
                begin
                    in_rows_reg <= cfg.data[bu2x_pkg::ROWS_W-1:0];
                end
            end
            if (acc)
            begin
                left_cur_reg <= pix;
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + RW'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (push)
            begin
                left_prev_reg <= s1_up_reg;
            end
            if (acc)
            begin
                s1_vld_reg <= 1'b1;
            end
            else if (push)
            begin
                s1_vld_reg <= 1'b0;
            end
        end
    end

    // line store, read-before-write on the same column
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_up_reg      <= store[col_reg];
            store[col_reg] <= pix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_px_reg       <= pix;
            s1_left_reg     <= left_cur_reg;
            s1_row_reg      <= bu2x_pkg::RTAG_W'(row_reg);
            s1_col_reg      <= bu2x_pkg::CTAG_W'(col_reg);
            s1_above_reg    <= (row_reg != '0);
            s1_left_ok_reg  <= (col_reg != '0);
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
        end
    end

    always_comb
    begin
        push_word.cur0      = bu2x_pkg::px_mean(s1_left_reg, s1_px_reg);
        push_word.cur       = s1_px_reg;
        push_word.upv0      = bu2x_pkg::px_mean(left_prev_reg, s1_up_reg);
        push_word.upv       = s1_up_reg;
        push_word.row       = s1_row_reg;
        push_word.col       = s1_col_reg;
        push_word.has_above = s1_above_reg;
        push_word.has_left  = s1_left_ok_reg;
        push_word.last_col  = s1_last_col_reg;
        push_word.last_row  = s1_last_row_reg;
    end

endmodule

/* hw/rtl/bu2x_queue.sv */
// ----------------------------------------------------------------------------
// bu2x_queue
// Two-word queue between front and back.
// ----------------------------------------------------------------------------
module bu2x_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bu2x_pkg::q_entry_t  push_word,
    output logic                full,
    input  logic                pop,
    output bu2x_pkg::q_entry_t  head,
    output logic                head_valid
);

    bu2x_pkg::q_entry_t                mem_reg [bu2x_pkg::QDEPTH];
    logic [bu2x_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [bu2x_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [bu2x_pkg::QCNT_W-1:0]       cnt_reg;

    assign full       = (cnt_reg == bu2x_pkg::QCNT_W'(bu2x_pkg::QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + bu2x_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + bu2x_pkg::QPTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + bu2x_pkg::QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - bu2x_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

/* hw/rtl/bu2x_back.sv */
// ----------------------------------------------------------------------------
// bu2x_back
// Walks the output rows and columns of the head word, one result per cycle
// into an output register, unless that register is held by a stalled result.
// ----------------------------------------------------------------------------
module bu2x_back (
    input  logic                clk,
    input  logic                rst_n,
    input  bu2x_pkg::q_entry_t  head,
    input  logic                head_valid,
    output logic                pop,
    bu2x_res_if.source          result
);

    logic                          started_reg;
    logic [1:0]                    ph_reg;
    logic [1:0]                    k_reg;
    logic                          out_vld_reg;
    logic [bu2x_pkg::OROW_W-1:0]   out_row_reg;
    logic [bu2x_pkg::OCOL_W-1:0]   out_col_reg;
    bu2x_pkg::px_t                 out_px_reg;
    logic                          out_last_reg;

    logic [1:0]    rstart;
    logic [1:0]    rend;
    logic [1:0]    kstart;
    logic [1:0]    kend;
    logic [1:0]    ph;
    logic [1:0]    kk;
    logic          produce;
    logic          row_done;
    logic          last;
    bu2x_pkg::px_t cur_k;
    bu2x_pkg::px_t up_k;
    bu2x_pkg::px_t px;

    assign rstart = head.has_above ? bu2x_pkg::PH_ABOVE : bu2x_pkg::PH_SAME;
    assign rend   = head.last_row  ? bu2x_pkg::PH_BELOW : bu2x_pkg::PH_SAME;
    assign kstart = head.has_left  ? bu2x_pkg::K_LEFT   : bu2x_pkg::K_MID;
    assign kend   = head.last_col  ? bu2x_pkg::K_RIGHT  : bu2x_pkg::K_MID;
    assign ph     = started_reg ? ph_reg : rstart;
    assign kk     = started_reg ? k_reg  : kstart;

    assign produce  = head_valid && (!out_vld_reg || result.ready);
    assign row_done = (kk == kend);
    assign last     = row_done && (ph == rend);
    assign pop      = produce && last;

    assign cur_k = (kk == bu2x_pkg::K_LEFT) ? head.cur0 : head.cur;
    assign up_k  = (kk == bu2x_pkg::K_LEFT) ? head.upv0 : head.upv;
    assign px    = (ph == bu2x_pkg::PH_ABOVE) ? bu2x_pkg::px_mean(up_k, cur_k) : cur_k;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            ph_reg      <= bu2x_pkg::PH_ABOVE;
            k_reg       <= bu2x_pkg::K_LEFT;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (produce)
            begin
                started_reg <= !last;
                if (row_done)
                begin
                    k_reg  <= kstart;
                    ph_reg <= ph + 2'd1;
                end
                else
                begin
                    k_reg  <= kk + 2'd1;
                    ph_reg <= ph;
                end
            end
            if (produce)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            out_row_reg  <= {head.row, 1'b0} + bu2x_pkg::OROW_W'(ph)
                            - bu2x_pkg::OROW_W'(1);
            out_col_reg  <= {head.col, 1'b0} + bu2x_pkg::OCOL_W'(kk)
                            - bu2x_pkg::OCOL_W'(1);
            out_px_reg   <= px;
            out_last_reg <= last;
        end
    end

    assign result.valid       = out_vld_reg;
    assign result.out_row     = out_row_reg;
    assign result.out_col     = out_col_reg;
    assign result.out_blue    = out_px_reg[7:0];
    assign result.out_green   = out_px_reg[15:8];
    assign result.out_red     = out_px_reg[23:16];
    assign result.last_of_run = out_last_reg;

`ifndef SYNTHESIS
    a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> !started_reg)
        else $error("walk state not cleared after last result");

    a_started_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> head_valid)
        else $error("walk in progress without a queued word");

    a_mid_keeps_word: assert property (@(posedge clk) disable iff (!rst_n)
        (produce && !last) |=> (started_reg && head_valid))
        else $error("word dropped before its last result");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        produce |=> (out_last_reg == $past(pop)))
        else $error("last_of_run does not match queue pop");
`endif

endmodule

/* hw/rtl/bilinear_upscale_2x.sv */
// ----------------------------------------------------------------------------
// bilinear_upscale_2x
// Path: front stage register, two-word queue, then the output register.
// Throughput: one result per cycle from the output register while the result
// side is ready; a pixel yields 1 to 9 results (4 in the picture interior).
// Reset: counters and left pixels cleared, size registers back to 2048 x 4096
// at once; line store is not cleared, and first-row reads of it go unused.
// ----------------------------------------------------------------------------
module bilinear_upscale_2x #(
    parameter int MAX_COLS = 2048,
    parameter int MAX_ROWS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    bu2x_pix_if.sink    pixel,
    bu2x_cfg_if.sink    cfg,
    bu2x_res_if.source  result
);

    logic               push;
    logic               q_full;
    logic               pop;
    logic               head_valid;
    bu2x_pkg::q_entry_t push_word;
    bu2x_pkg::q_entry_t head;

    bu2x_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .cfg       (cfg),
        .push      (push),
        .push_word (push_word),
        .q_full    (q_full)
    );

    bu2x_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (push_word),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    bu2x_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .result     (result)
    );

endmodule

/* tb/bilinear_upscale_2x_test.sv */
// ----------------------------------------------------------------------------
// bilinear_upscale_2x_test
// Self-checking bench for the 2x bilinear upscaler. Pixels go in through the
// valid/ready pixel channel with random gaps. Every accepted pixel is run
// through a local model of the enlargement, which queues the output words it
// must produce. The result channel is stalled at random, and once for a long
// stretch. Each result word is compared with the oldest queued word.
// Covered: reset sizes, clamped and shrunk sizes with the position left past
// the end of a row or picture, small pictures, a long output stall and
// random pictures, some cut short.
// ----------------------------------------------------------------------------
module bilinear_upscale_2x_test;

    localparam int MAX_COLS     = 2048;
    localparam int MAX_ROWS     = 4096;
    localparam int HOLD_CYCLES  = 400;
    localparam int RESET_ITEMS  = 6;
    localparam int RANDOM_ITEMS = 140;
    localparam int LIMIT_CYCLES = 2_000_000;

    typedef struct packed {
        logic [bu2x_pkg::OROW_W-1:0] out_row;
        logic [bu2x_pkg::OCOL_W-1:0] out_col;
        logic [7:0]                  red;
        logic [7:0]                  green;
        logic [7:0]                  blue;
        logic                        last_of_run;
    } px_word_t;

    logic clk;
    logic rst_n;

    bu2x_pix_if pix ();
    bu2x_cfg_if cfg ();
    bu2x_res_if res ();

    bilinear_upscale_2x dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix),
        .cfg    (cfg),
        .result (res)
    );

    // model state
    logic [bu2x_pkg::COLS_W-1:0] cols_reg = bu2x_pkg::IN_COLS_RST;
    logic [bu2x_pkg::ROWS_W-1:0] rows_reg = bu2x_pkg::IN_ROWS_RST;
    bu2x_pkg::px_t               row_above_mem [0:MAX_COLS-1];
    bu2x_pkg::px_t               left_px       = '0;
    bu2x_pkg::px_t               upper_left_px = '0;
    int                          in_row        = 0;
    int                          in_col        = 0;

    px_word_t enlarged_px_q [$];

    int errors   = 0;
    bit idle_on  = 1'b1;
    int hold_req = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        #(LIMIT_CYCLES * 10);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int gap_len();
        int pick;
        if (!idle_on)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 16);
    endfunction

    function automatic bu2x_pkg::px_t random_px();
        bu2x_pkg::px_t p;
        int            ch;
        for (ch = 0; ch < 3; ch++)
        begin
            case ($urandom_range(0, 7))
                0:       p[ch*8 +: 8] = 8'h00;
                1:       p[ch*8 +: 8] = 8'hFF;
                default: p[ch*8 +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return p;
    endfunction

    function automatic bu2x_pkg::px_t avg_px(input bu2x_pkg::px_t a, input bu2x_pkg::px_t b);
        bu2x_pkg::px_t m;
        int            ch;
        for (ch = 0; ch < 3; ch++)
            m[ch*8 +: 8] = 8'((9'(a[ch*8 +: 8]) + 9'(b[ch*8 +: 8])) >> 1);
        return m;
    endfunction

    // queue every output word completed by input pixel p, then advance position
    function automatic void enlarge_pixel(input bu2x_pkg::px_t p);
        int            ncols;
        int            nrows;
        int            c;
        int            r;
        int            ph;
        int            k;
        int            kfirst;
        int            klast;
        bit            last_col;
        bit            last_row;
        bu2x_pkg::px_t up;
        bu2x_pkg::px_t cur [3];
        bu2x_pkg::px_t upv [3];
        px_word_t      w;
        px_word_t      run [$];
        ncols = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg));
        nrows = (rows_reg == 0) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg));
        c = in_col;
        r = in_row;
        up = row_above_mem[c];
        last_col = (c + 1 >= ncols);
        last_row = (r + 1 >= nrows);
        kfirst = (c > 0) ? bu2x_pkg::K_LEFT : bu2x_pkg::K_MID;
        klast  = last_col ? bu2x_pkg::K_RIGHT : bu2x_pkg::K_MID;
        cur[bu2x_pkg::K_LEFT]  = avg_px(left_px, p);
        cur[bu2x_pkg::K_MID]   = p;
        cur[bu2x_pkg::K_RIGHT] = p;
        upv[bu2x_pkg::K_LEFT]  = avg_px(upper_left_px, up);
        upv[bu2x_pkg::K_MID]   = up;
        upv[bu2x_pkg::K_RIGHT] = up;
        for (ph = bu2x_pkg::PH_ABOVE; ph <= bu2x_pkg::PH_BELOW; ph++)
        begin
            if (!((ph == bu2x_pkg::PH_ABOVE && r == 0)
                  || (ph == bu2x_pkg::PH_BELOW && !last_row)))
            begin
                for (k = kfirst; k <= klast; k++)
                begin
                    w.out_row = bu2x_pkg::OROW_W'(2 * r + ph - 1);
                    w.out_col = bu2x_pkg::OCOL_W'(2 * c + k - 1);
                    {w.red, w.green, w.blue} = (ph == bu2x_pkg::PH_ABOVE)
                                             ? avg_px(upv[k], cur[k]) : cur[k];
                    w.last_of_run = 1'b0;
                    run.push_back(w);
                end
            end
        end
        run[run.size() - 1].last_of_run = 1'b1;
        foreach (run[i])
            enlarged_px_q.push_back(run[i]);
        row_above_mem[c] = p;
        left_px = p;
        upper_left_px = up;
        if (last_col)
        begin
            in_col = 0;
            in_row = last_row ? 0 : r + 1;
        end
        else
        begin
            in_col = c + 1;
        end
    endfunction

    function automatic void check_result();
        px_word_t got;
        px_word_t want;
        got = {res.out_row, res.out_col, res.out_red, res.out_green, res.out_blue,
               res.last_of_run};
        if (enlarged_px_q.size() == 0)
        begin
            errors++;
            if (errors <= 200)
                $display("%0t: unexpected word row %0d col %0d rgb %h%h%h last %b",
                         $time, got.out_row, got.out_col, got.red, got.green, got.blue,
                         got.last_of_run);
        end
        else
        begin
            want = enlarged_px_q.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 200)
                    $display("%0t: word mismatch exp row %0d col %0d rgb %h%h%h last %b, %s",
                             $time, want.out_row, want.out_col, want.red, want.green,
                             want.blue, want.last_of_run,
                             $sformatf("got row %0d col %0d rgb %h%h%h last %b",
                                       got.out_row, got.out_col, got.red, got.green,
                                       got.blue, got.last_of_run));
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            check_result();
    end

    initial
    begin : result_ready_drive
        int stall;
        int hold_left;
        int hold_seen;
        stall = 0;
        hold_left = 0;
        hold_seen = 0;
        res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                res.ready <= 1'b0;
                hold_left--;
            end
            else if (stall > 0)
            begin
                res.ready <= 1'b0;
                stall--;
            end
            else
            begin
                res.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = gap_len();
            end
        end
    end

    task automatic offer_pixel(input bu2x_pkg::px_t p);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid    <= 1'b1;
        pix.in_blue  <= p[7:0];
        pix.in_green <= p[15:8];
        pix.in_red   <= p[23:16];
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        enlarge_pixel(p);
    endtask

    // wait for all queued words, then let the pipeline go idle
    task automatic settle();
        pix.valid <= 1'b0;
        while (enlarged_px_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bu2x_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        settle();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value[bu2x_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        if (idx == bu2x_pkg::REG_IN_COLS)
            cols_reg = value[bu2x_pkg::COLS_W-1:0];
        else
            rows_reg = value[bu2x_pkg::ROWS_W-1:0];
    endtask

    // reset sizes; a few pixels on the first row
    task automatic test_reset_sizes();
        int i;
        idle_on = 1'b1;
        for (i = 0; i < RESET_ITEMS; i++)
            offer_pixel(random_px());
    endtask

    // clamped sizes and a position left past the end of a shrunk row or picture
    task automatic test_counter_overrun();
        int i;
        write_reg(bu2x_pkg::REG_IN_COLS, 4095);
        write_reg(bu2x_pkg::REG_IN_ROWS, 8191);
        for (i = 0; i < 4; i++)
            offer_pixel(random_px());
        write_reg(bu2x_pkg::REG_IN_COLS, 0);
        offer_pixel(24'hFFFFFF);
        offer_pixel(24'h000000);
        write_reg(bu2x_pkg::REG_IN_ROWS, 0);
        offer_pixel(24'h01FE80);
    endtask

    task automatic test_small_pictures();
        bu2x_pkg::px_t pat [9];
        int            n;
        int            i;
        pat = '{24'hFFFFFF, 24'h000000, 24'h01FE80, 24'hFE017F, 24'hFF00FF,
                24'h00FF00, 24'h808080, 24'h7F7F81, 24'hAA55AA};
        for (n = 1; n <= 3; n++)
        begin
            write_reg(bu2x_pkg::REG_IN_COLS, n);
            write_reg(bu2x_pkg::REG_IN_ROWS, n);
            for (i = 0; i < n * n; i++)
                offer_pixel(pat[i]);
        end
    endtask

    // result side held off while pixels keep coming; input must back up
    task automatic test_output_stall();
        int i;
        write_reg(bu2x_pkg::REG_IN_COLS, MAX_COLS);
        write_reg(bu2x_pkg::REG_IN_ROWS, 1);
        idle_on = 1'b0;
        hold_req++;
        for (i = 0; i < 40; i++)
            offer_pixel(random_px());
        idle_on = 1'b1;
        write_reg(bu2x_pkg::REG_IN_COLS, 1);
        offer_pixel(random_px());
    endtask

    task automatic test_random_pictures();
        int sent;
        int ncols;
        int nrows;
        int count;
        int full;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            ncols = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
            nrows = $urandom_range(0, 5);
            write_reg(bu2x_pkg::REG_IN_COLS, ncols);
            write_reg(bu2x_pkg::REG_IN_ROWS, nrows);
            idle_on = ($urandom_range(0, 3) != 0);
            full = (ncols == 0 ? 1 : ncols) * (nrows == 0 ? 1 : nrows);
            count = full;
            // some pictures are cut short
            if ($urandom_range(0, 5) == 0)
                count = $urandom_range(1, count);
            if (count > RANDOM_ITEMS - sent)
                count = RANDOM_ITEMS - sent;
            repeat (count) offer_pixel(random_px());
            sent += count;
            // a cut picture is closed through a one-pixel size
            if (count < full)
            begin
                write_reg(bu2x_pkg::REG_IN_COLS, 1);
                write_reg(bu2x_pkg::REG_IN_ROWS, 1);
                offer_pixel(random_px());
                sent++;
            end
        end
        idle_on = 1'b1;
    endtask

    initial
    begin : run_tests
        rst_n        = 1'b0;
        pix.valid    = 1'b0;
        pix.in_blue  = '0;
        pix.in_green = '0;
        pix.in_red   = '0;
        cfg.valid    = 1'b0;
        cfg.index    = bu2x_pkg::REG_IN_COLS;
        cfg.data     = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_sizes();
        test_counter_overrun();
        test_small_pictures();
        test_output_stall();
        test_random_pictures();

        settle();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/bu2x_pkg.sv
hw/rtl/bu2x_if.sv
hw/rtl/bu2x_front.sv
hw/rtl/bu2x_queue.sv
hw/rtl/bu2x_back.sv
hw/rtl/bilinear_upscale_2x.sv
tb/bilinear_upscale_2x_test.sv
